// ----- src/kssg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kssg_pkg
// Shared types and constants of the k-mer successor sequence generator.
// ----------------------------------------------------------------------------
package kssg_pkg;

  // Field and port widths
  localparam int MAX_K_DEF  = 8;
  localparam int KLEN_W     = 4;
  localparam int BASE_W     = 2;
  localparam int CUT_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // Register reset values
  localparam logic [KLEN_W-1:0] KLEN_RST = KLEN_W'(8);
  localparam logic [BASE_W-1:0] MAP0_RST = 2'd2;
  localparam logic [BASE_W-1:0] MAP1_RST = 2'd0;
  localparam logic [BASE_W-1:0] MAP2_RST = 2'd1;
  localparam logic [BASE_W-1:0] MAP3_RST = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_BASE0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_BASE1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_BASE2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_BASE3   = 3'd4;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EMIT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic restart;     // clear walk state, emit status beat, rewind sweep
    logic clear_step;  // zero one visited entry, advance sweep address
    logic lookup;      // latch current k-mer, read its mark
    logic finish;      // set done, emit status beat
    logic skip;        // visited k-mer: cut chain, move to next start
    logic mark;        // set mark of current k-mer
    logic first;       // emit leading base of chain, start prefix shift
    logic prefix;      // emit next prefix base
    logic final_base;  // emit successor base, advance walk
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_end;     // sweep is at the last entry
    logic at_end;        // walk done or start beyond k-mer space
    logic hit;           // current k-mer already marked
    logic chain_started; // chain has emitted its prefix
    logic prefix_left;   // prefix bases still to emit
  } status_t;

endpackage

// ----- src/kmer_successor_sequence_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_successor_sequence_generator
// DNA base stream from a successor walk over all k-mers.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   restart_i = 1 clears walk state and the visited bitmap; restart_i = 0
//   advances the walk by one step.
//   Result channel: each beat is shown for one cycle with result_valid_o
//   high; the receiver cannot stall, so beats are never held back.
//   Config channel: cfg_ready_o is always high; write only while idle.
// Timing:
//   A finished walk answers in the cycle after the item. A normal step
//   goes through accept and a bitmap read, the mark coming from the registered
//   bitmap read port; the first step of a chain then streams k further bases,
//   one per cycle. The first beat appears in the cycle after the deciding
//   cycle.
// Reset and restart:
//   Both sweep the 4^MAX_K entry bitmap one entry a cycle (65536 entries at
//   MAX_K = 8); busy stays high through the sweep. A restart shows its
//   status beat in the first cycle of its sweep.
// ----------------------------------------------------------------------------
module kmer_successor_sequence_generator
  import kssg_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  restart_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  result_valid_o,
  output logic [BASE_W-1:0]     base_o,
  output logic                  base_valid_o,
  output logic                  last_o,
  output logic                  finished_o,
  output logic [CUT_W-1:0]      cut_total_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  kssg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .restart_i (restart_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  // Walk datapath and bitmap
  kssg_datapath #(
    .MAX_K (MAX_K)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .base_o         (base_o),
    .base_valid_o   (base_valid_o),
    .last_o         (last_o),
    .finished_o     (finished_o),
    .cut_total_o    (cut_total_o)
  );

  // A status beat carries no base and closes its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !base_valid_o) |-> (last_o && base_o == '0))
    else $error("status beat with base or without last");

  // A finished walk emits no bases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && finished_o) |-> !base_valid_o)
    else $error("base emitted after walk finished");

  // Restart answers next cycle with cleared counters and sweeps the bitmap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && restart_i) |=>
      (result_valid_o && busy && cut_total_o == '0 && !finished_o))
    else $error("restart did not clear walk state");

  // Only one command is active at a time in the bitmap write path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.clear_step && cmd.mark))
    else $error("bitmap sweep and mark collide");

endmodule

// ----- src/kssg_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kssg_ctrl
// Sequencer of the walk: clearing sweep, lookup, and base emission.
// ----------------------------------------------------------------------------
module kssg_ctrl
  import kssg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    restart_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy
);

  state_e state_q, state_d;

  // State register; reset starts with a sweep of the visited store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (restart_i)             state_d = ST_CLEAR;
          else if (!status_i.at_end) state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (status_i.hit || status_i.chain_started) state_d = ST_IDLE;
        else                                        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.prefix_left) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (restart_i)            cmd_o.restart = 1'b1;
          else if (status_i.at_end) cmd_o.finish  = 1'b1;
          else                      cmd_o.lookup  = 1'b1;
        end
      end
      ST_LOOK: begin
        if (status_i.hit) begin
          cmd_o.skip = 1'b1;
        end else begin
          cmd_o.mark = 1'b1;
          if (status_i.chain_started) cmd_o.final_base = 1'b1;
          else                        cmd_o.first      = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status_i.prefix_left) cmd_o.prefix     = 1'b1;
        else                      cmd_o.final_base = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- src/kssg_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kssg_datapath
// Walk registers, visited bitmap, configuration registers and result beat.
// ----------------------------------------------------------------------------
module kssg_datapath
  import kssg_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic                  result_valid_o,
  output logic [BASE_W-1:0]     base_o,
  output logic                  base_valid_o,
  output logic                  last_o,
  output logic                  finished_o,
  output logic [CUT_W-1:0]      cut_total_o
);

  localparam int AW = 2 * MAX_K;
  localparam int NK = 1 << AW;
  localparam logic [KLEN_W-1:0] KMAX = KLEN_W'(MAX_K);

  // Configuration registers
  logic [KLEN_W-1:0] klen_q;
  logic [BASE_W-1:0] map_q [4];

  // Walk state
  logic [AW:0]       start_q;
  logic [AW-1:0]     walk_q;
  logic [AW-1:0]     cur_q;
  logic [AW-1:0]     sh_q;
  logic [AW-1:0]     clr_addr_q;
  logic [KLEN_W-1:0] cnt_q;
  logic              chain_q;
  logic              done_q;
  logic [CUT_W-1:0]  cut_q;

  // Result beat
  logic              out_valid_q;
  logic [BASE_W-1:0] base_q;
  logic              bvalid_q;
  logic              last_q;

  // Visited bitmap
  logic              mem [NK];
  logic              rd_q;

  logic [KLEN_W-1:0] k;
  logic [AW-1:0]     kmask;
  logic [AW-1:0]     cmask;
  logic [AW-1:0]     al;
  logic [AW-1:0]     centre;
  logic [BASE_W-1:0] lead;
  logic [BASE_W-1:0] nb;
  logic [AW-1:0]     walk_next;
  logic [AW:0]       start_inc;

  // Clamp length and build k-mer masks
  always_comb begin
    if (klen_q == '0)     k = KLEN_W'(1);
    else if (klen_q > KMAX) k = KMAX;
    else                    k = klen_q;
    for (int j = 0; j < AW; j++) begin
      kmask[j] = (j < 2 * int'(k));
    end
    cmask = kmask >> 2;
  end

  // Successor base of the current k-mer
  always_comb begin
    al        = cur_q << (AW - 2 * int'(k));
    lead      = al[AW-1 -: BASE_W];
    centre    = cur_q & cmask;
    nb        = map_q[lead] ^ {BASE_W{centre[0]}};
    walk_next = ((centre << 2) | AW'(nb)) & kmask;
    start_inc = start_q + 1'b1;
  end

  assign status_o.clear_end     = (clr_addr_q == {AW{1'b1}});
  assign status_o.at_end        = done_q || (start_q > {1'b0, kmask});
  assign status_o.hit           = rd_q;
  assign status_o.chain_started = chain_q;
  assign status_o.prefix_left   = (cnt_q < k);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q   <= KLEN_RST;
      map_q[0] <= MAP0_RST;
      map_q[1] <= MAP1_RST;
      map_q[2] <= MAP2_RST;
      map_q[3] <= MAP3_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_KMER_LENGTH: klen_q   <= cfg_data_i[KLEN_W-1:0];
        CFG_MAP_BASE0:   map_q[0] <= cfg_data_i[BASE_W-1:0];
        CFG_MAP_BASE1:   map_q[1] <= cfg_data_i[BASE_W-1:0];
        CFG_MAP_BASE2:   map_q[2] <= cfg_data_i[BASE_W-1:0];
        CFG_MAP_BASE3:   map_q[3] <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Bitmap: one write port, registered read of the current walk k-mer
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      mem[clr_addr_q] <= 1'b0;
    end else if (cmd_i.mark) begin
      mem[cur_q] <= 1'b1;
    end
    rd_q <= mem[walk_q & kmask];
  end

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      walk_q     <= '0;
      chain_q    <= 1'b0;
      done_q     <= 1'b0;
      cut_q      <= '0;
      clr_addr_q <= '0;
      cnt_q      <= '0;
    end else begin
      if (cmd_i.restart) begin
        start_q    <= '0;
        walk_q     <= '0;
        chain_q    <= 1'b0;
        done_q     <= 1'b0;
        cut_q      <= '0;
        clr_addr_q <= '0;
      end
      if (cmd_i.clear_step) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.finish) begin
        done_q <= 1'b1;
      end
      // Visited: cut the chain and move to the next start
      if (cmd_i.skip) begin
        if (chain_q && (cut_q != {CUT_W{1'b1}})) cut_q <= cut_q + 1'b1;
        chain_q <= 1'b0;
        start_q <= start_inc;
        if (start_inc > {1'b0, kmask}) done_q <= 1'b1;
        else                           walk_q <= start_inc[AW-1:0];
      end
      if (cmd_i.first) begin
        chain_q <= 1'b1;
        cnt_q   <= KLEN_W'(1);
      end
      if (cmd_i.prefix) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.final_base) begin
        walk_q <= walk_next;
      end
    end
  end

  // Latch current k-mer and prefix shifter
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      cur_q <= walk_q & kmask;
    end
    if (cmd_i.first) begin
      sh_q <= al << 2;
    end else if (cmd_i.prefix) begin
      sh_q <= sh_q << 2;
    end
  end

  // Result beat strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.restart | cmd_i.finish | cmd_i.skip | cmd_i.first
                   | cmd_i.prefix | cmd_i.final_base;
    end
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.first) begin
      base_q   <= lead;
      bvalid_q <= 1'b1;
      last_q   <= 1'b0;
    end else if (cmd_i.prefix) begin
      base_q   <= sh_q[AW-1 -: BASE_W];
      bvalid_q <= 1'b1;
      last_q   <= 1'b0;
    end else if (cmd_i.final_base) begin
      base_q   <= nb;
      bvalid_q <= 1'b1;
      last_q   <= 1'b1;
    end else begin
      base_q   <= '0;
      bvalid_q <= 1'b0;
      last_q   <= 1'b1;
    end
  end

  assign result_valid_o = out_valid_q;
  assign base_o         = base_q;
  assign base_valid_o   = bvalid_q;
  assign last_o         = last_q;
  assign finished_o     = done_q;
  assign cut_total_o    = cut_q;

endmodule
